@@ rtl/fdlm_pkg.sv @@
// Fault debounce latch manager: shared types, operation codes and the fault rule table.
// No dependencies; used by the top level through scoped names.
`default_nettype none

package fdlm_pkg;

  localparam int TABLE_ROWS = 15;
  localparam int MAX_FAULTS = 64;

  localparam logic [1:0] OP_REPORT = 2'd0;
  localparam logic [1:0] OP_ACK    = 2'd1;
  localparam logic [1:0] OP_BEGIN  = 2'd2;

  localparam logic [2:0] SEV_INFO     = 3'd0;
  localparam logic [2:0] SEV_WARN     = 3'd1;
  localparam logic [2:0] SEV_DERATE   = 3'd2;
  localparam logic [2:0] SEV_LIMP     = 3'd3;
  localparam logic [2:0] SEV_CRITICAL = 3'd4;

  typedef struct packed {
    logic [2:0]  severity;
    logic [15:0] debounce;
    logic [15:0] heal;
    logic        latching;
  } rule_t;

  // Rows past the table: info, zero debounce, zero heal, not latching.
  function automatic rule_t rule_of(input logic [5:0] idx);
    rule_t r;
    begin
      r = '{SEV_INFO, 16'd0, 16'd0, 1'b0};
      case (idx)
        6'd0:    r = '{SEV_CRITICAL, 16'd0,   16'd0,    1'b0};
        6'd1:    r = '{SEV_CRITICAL, 16'd20,  16'd500,  1'b0};
        6'd2:    r = '{SEV_LIMP,     16'd0,   16'd0,    1'b0};
        6'd3:    r = '{SEV_WARN,     16'd50,  16'd500,  1'b0};
        6'd4:    r = '{SEV_CRITICAL, 16'd0,   16'd0,    1'b1};
        6'd5:    r = '{SEV_CRITICAL, 16'd0,   16'd0,    1'b1};
        6'd6:    r = '{SEV_CRITICAL, 16'd100, 16'd1000, 1'b0};
        6'd7:    r = '{SEV_CRITICAL, 16'd50,  16'd1000, 1'b1};
        6'd8:    r = '{SEV_CRITICAL, 16'd100, 16'd1000, 1'b0};
        6'd9:    r = '{SEV_CRITICAL, 16'd50,  16'd1000, 1'b1};
        6'd10:   r = '{SEV_DERATE,   16'd200, 16'd2000, 1'b0};
        6'd11:   r = '{SEV_DERATE,   16'd500, 16'd5000, 1'b0};
        6'd12:   r = '{SEV_DERATE,   16'd500, 16'd5000, 1'b0};
        6'd13:   r = '{SEV_LIMP,     16'd50,  16'd500,  1'b0};
        6'd14:   r = '{SEV_CRITICAL, 16'd100, 16'd1000, 1'b0};
        default: r = '{SEV_INFO, 16'd0, 16'd0, 1'b0};
      endcase
      return r;
    end
  endfunction

  // Mask of latching faults, one bit per fault.
  function automatic logic [MAX_FAULTS-1:0] latch_mask();
    logic [MAX_FAULTS-1:0] m;
    rule_t r;
    begin
      m = '0;
      for (int i = 0; i < MAX_FAULTS; i++) begin
        r = rule_of(6'(i));
        m[i] = r.latching;
      end
      return m;
    end
  endfunction

  // Mask of faults carrying the given severity.
  function automatic logic [MAX_FAULTS-1:0] sev_mask(input logic [2:0] sev);
    logic [MAX_FAULTS-1:0] m;
    rule_t r;
    begin
      m = '0;
      for (int i = 0; i < MAX_FAULTS; i++) begin
        r = rule_of(6'(i));
        m[i] = (r.severity == sev);
      end
      return m;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/fdlm_timer_store.sv @@
// Fault debounce latch manager: per-fault timer memory (present and absent timers).
// One synchronous RAM with registered read; per-entry valid bits make unwritten entries read zero.
`default_nettype none

module fdlm_timer_store #(
  parameter int NUM_FAULTS = 15,
  parameter int TIMER_BITS = 16,
  parameter int ADDR_W     = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_W-1:0]     rd_addr,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_W-1:0]     wr_addr,
  input  wire logic [TIMER_BITS-1:0] wr_present,
  input  wire logic [TIMER_BITS-1:0] wr_absent,
  output logic      [TIMER_BITS-1:0] rd_present,
  output logic      [TIMER_BITS-1:0] rd_absent
);

  logic [2*TIMER_BITS-1:0] mem [NUM_FAULTS];
  logic [NUM_FAULTS-1:0]   written;
  logic [2*TIMER_BITS-1:0] rd_data;
  logic                    rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_present, wr_absent};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= written[rd_addr];
      end
    end
  end

  // never-written entry reads as its reset value of zero
  assign rd_present = rd_ok ? rd_data[2*TIMER_BITS-1:TIMER_BITS] : '0;
  assign rd_absent  = rd_ok ? rd_data[TIMER_BITS-1:0] : '0;

endmodule

`default_nettype wire

@@ rtl/fault_debounce_latch_manager.sv @@
// Debounced fault manager with latching: top level.
// Timing: the timer RAM is read when a word is accepted, and the modify step (S_RMW) loads
// the result word into the output registers when it advances, which a stalled output holds.
// No word is accepted during the timer RAM read-modify-write (req_stall is high); the next
// word is taken while a result still waits, and the update holds while the output is stalled.
// Reset (rst, synchronous): internal fault masks cleared, all timers read as zero, no result pending.
`default_nettype none

module fault_debounce_latch_manager #(
  parameter int NUM_FAULTS = 15,
  parameter int TIMER_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [3:0]  fault_index,
  input  wire logic        condition_present,
  input  wire logic [15:0] elapsed_ms,
  // response channel
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [14:0]      active_mask,
  output logic [14:0]      set_mask,
  output logic [14:0]      cleared_mask,
  output logic [2:0]       worst_severity
);

  localparam int ADDR_W = (NUM_FAULTS > 1) ? $clog2(NUM_FAULTS) : 1;
  // sum wide enough for timer plus a 16-bit step, and for the 16-bit table thresholds
  localparam int SUM_W  = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;
  localparam logic [SUM_W-1:0] TMAX =
    {{(SUM_W-TIMER_BITS){1'b0}}, {TIMER_BITS{1'b1}}};
  localparam logic [NUM_FAULTS-1:0] ONE_HOT0 = NUM_FAULTS'(1);

  localparam logic [NUM_FAULTS-1:0] LATCH_M =
    NUM_FAULTS'(fdlm_pkg::latch_mask());
  localparam logic [NUM_FAULTS-1:0] SEV1_M =
    NUM_FAULTS'(fdlm_pkg::sev_mask(fdlm_pkg::SEV_WARN));
  localparam logic [NUM_FAULTS-1:0] SEV2_M =
    NUM_FAULTS'(fdlm_pkg::sev_mask(fdlm_pkg::SEV_DERATE));
  localparam logic [NUM_FAULTS-1:0] SEV3_M =
    NUM_FAULTS'(fdlm_pkg::sev_mask(fdlm_pkg::SEV_LIMP));
  localparam logic [NUM_FAULTS-1:0] SEV4_M =
    NUM_FAULTS'(fdlm_pkg::sev_mask(fdlm_pkg::SEV_CRITICAL));

  typedef enum logic {S_IDLE, S_RMW} state_t;

  state_t state;

  // captured request word
  logic [1:0]        op;
  logic [ADDR_W-1:0] addr;
  logic [5:0]        idx6;
  logic              rep_ok;
  logic              present;
  logic [15:0]       dt;

  // fault state kept in flops
  logic [NUM_FAULTS-1:0] active;
  logic [NUM_FAULTS-1:0] nset;
  logic [NUM_FAULTS-1:0] nclr;
  logic [NUM_FAULTS-1:0] pzero;   // present timer is zero, per fault

  logic accept;
  logic advance;
  logic [6:0]        in_idx7;
  logic              in_rep_ok;
  logic [ADDR_W-1:0] in_addr;

  logic [TIMER_BITS-1:0] rd_present;
  logic [TIMER_BITS-1:0] rd_absent;
  logic [TIMER_BITS-1:0] wr_present;
  logic [TIMER_BITS-1:0] wr_absent;
  logic                  wr_en;

  fdlm_pkg::rule_t       rule;
  logic [SUM_W-1:0]      sum_p;
  logic [SUM_W-1:0]      sum_a;
  logic [TIMER_BITS-1:0] sat_p;
  logic [TIMER_BITS-1:0] sat_a;
  logic [NUM_FAULTS-1:0] bit_sel;
  logic                  do_set;
  logic                  do_heal;
  logic [NUM_FAULTS-1:0] ack_clr;

  logic [NUM_FAULTS-1:0] active_next;
  logic [NUM_FAULTS-1:0] nset_next;
  logic [NUM_FAULTS-1:0] nclr_next;
  logic [NUM_FAULTS-1:0] pzero_next;
  logic [2:0]            worst_next;
  logic [63:0]           act64;
  logic [63:0]           set64;
  logic [63:0]           clr64;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  // result leaves the modify step only when the output register is free or being emptied
  assign advance   = (state == S_RMW) && (!rsp_valid || !rsp_stall);

  assign in_idx7   = {3'b000, fault_index};
  assign in_rep_ok = (operation == fdlm_pkg::OP_REPORT) && (in_idx7 < 7'(NUM_FAULTS));
  assign in_addr   = ADDR_W'(in_idx7);

  fdlm_timer_store #(
    .NUM_FAULTS (NUM_FAULTS),
    .TIMER_BITS (TIMER_BITS),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (accept && in_rep_ok),
    .rd_addr    (in_addr),
    .wr_en      (wr_en),
    .wr_addr    (addr),
    .wr_present (wr_present),
    .wr_absent  (wr_absent),
    .rd_present (rd_present),
    .rd_absent  (rd_absent)
  );

  // modify step: saturating timer update and set / heal decision
  always_comb begin
    rule    = fdlm_pkg::rule_of(idx6);
    sum_p   = SUM_W'(rd_present) + SUM_W'(dt);
    sum_a   = SUM_W'(rd_absent) + SUM_W'(dt);
    sat_p   = (sum_p > TMAX) ? TMAX[TIMER_BITS-1:0] : sum_p[TIMER_BITS-1:0];
    sat_a   = (sum_a > TMAX) ? TMAX[TIMER_BITS-1:0] : sum_a[TIMER_BITS-1:0];
    bit_sel = ONE_HOT0 << addr;

    wr_present = present ? sat_p : '0;
    wr_absent  = present ? '0 : sat_a;
    wr_en      = advance && rep_ok;

    do_set  = present && ((active & bit_sel) == '0) &&
              (SUM_W'(sat_p) >= SUM_W'(rule.debounce));
    do_heal = !present && ((active & bit_sel) != '0) && !rule.latching &&
              (SUM_W'(sat_a) >= SUM_W'(rule.heal));

    // acknowledge: active latched faults whose present timer is zero
    ack_clr = active & LATCH_M & pzero;

    active_next = active;
    nset_next   = nset;
    nclr_next   = nclr;
    pzero_next  = pzero;
    case (op)
      fdlm_pkg::OP_REPORT: begin
        if (rep_ok) begin
          if (present) begin
            pzero_next = (sat_p == '0) ? (pzero | bit_sel) : (pzero & ~bit_sel);
          end else begin
            pzero_next = pzero | bit_sel;
          end
          if (do_set) begin
            active_next = active | bit_sel;
            nset_next   = nset | bit_sel;
          end
          if (do_heal) begin
            active_next = active & ~bit_sel;
            nclr_next   = nclr | bit_sel;
          end
        end
      end
      fdlm_pkg::OP_ACK: begin
        active_next = active & ~ack_clr;
        nclr_next   = nclr | ack_clr;
      end
      fdlm_pkg::OP_BEGIN: begin
        nset_next = '0;
        nclr_next = '0;
      end
      default: begin
        // unused code: state untouched, result shows current state
      end
    endcase

    if ((active_next & SEV4_M) != '0) begin
      worst_next = fdlm_pkg::SEV_CRITICAL;
    end else if ((active_next & SEV3_M) != '0) begin
      worst_next = fdlm_pkg::SEV_LIMP;
    end else if ((active_next & SEV2_M) != '0) begin
      worst_next = fdlm_pkg::SEV_DERATE;
    end else if ((active_next & SEV1_M) != '0) begin
      worst_next = fdlm_pkg::SEV_WARN;
    end else begin
      worst_next = fdlm_pkg::SEV_INFO;
    end

    act64 = 64'(active_next);
    set64 = 64'(nset_next);
    clr64 = 64'(nclr_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      active    <= '0;
      nset      <= '0;
      nclr      <= '0;
      pzero     <= '1;
    end else begin
      // a new result word loads, or the waiting one stays until taken
      rsp_valid <= advance || (rsp_valid && rsp_stall);
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RMW;
          end
        end
        S_RMW: begin
          if (advance) begin
            state          <= S_IDLE;
            active         <= active_next;
            nset           <= nset_next;
            nclr           <= nclr_next;
            pzero          <= pzero_next;
            active_mask    <= act64[14:0];
            set_mask       <= set64[14:0];
            cleared_mask   <= clr64[14:0];
            worst_severity <= worst_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers: request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= operation;
      addr    <= in_addr;
      idx6    <= in_idx7[5:0];
      rep_ok  <= in_rep_ok;
      present <= condition_present;
      dt      <= elapsed_ms;
    end
  end

endmodule

`default_nettype wire

@@ tb/fault_debounce_latch_manager_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for fault_debounce_latch_manager: a directed table, then random report,
// acknowledge, begin and spare words, each checked against a typed result or a local fault model.
// Depends on rtl/fdlm_pkg.sv (operation and severity codes) and the top level.

module fault_debounce_latch_manager_tb;

  localparam int FAULTS        = 15;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_WORDS  = 1250;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;

  // Operation 3 has no meaning; the block must leave its state alone.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // One result word.
  typedef struct packed {
    logic [14:0] active;
    logic [14:0] set_bits;
    logic [14:0] cleared;
    logic [2:0]  worst;
  } fault_status_t;

  // One request word plus, for directed rows, a result typed in by hand.
  typedef struct packed {
    logic [1:0]    op;
    logic [3:0]    fault_id;
    logic          present;
    logic [15:0]   elapsed;
    logic          typed;
    fault_status_t want;
  } stim_word_t;

  // Per-fault limits as specified for the block.
  typedef struct packed {
    logic [2:0]  sev;
    logic [15:0] set_after;
    logic [15:0] heal_after;
    logic        latches;
  } fault_limits_t;

  // Rows that leave the result to the model carry this in place of a typed one.
  localparam logic [48:0] PREDICT = '0;
  localparam logic        TYPED   = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  operation = fdlm_pkg::OP_REPORT;
  logic [3:0]  fault_index = 4'd0;
  logic        condition_present = 1'b0;
  logic [15:0] elapsed_ms = 16'd0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [14:0] active_mask;
  logic [14:0] set_mask;
  logic [14:0] cleared_mask;
  logic [2:0]  worst_severity;

  // Local copy of the fault state.
  logic [14:0] active_now    = '0;
  logic [14:0] set_since     = '0;
  logic [14:0] cleared_since = '0;
  logic [15:0] on_time  [FAULTS];
  logic [15:0] off_time [FAULTS];

  fault_status_t pending_status [$];
  stim_word_t    stim_words [$];

  int mismatches     = 0;
  int words_in       = 0;
  int results_seen   = 0;
  int sets_seen      = 0;
  int clears_seen    = 0;
  int cycle_count    = 0;
  // Idling mix: sender 27 / receiver 67 first, swapped in the middle third, none at the end.
  int send_pct       = 27;
  int rsp_pct        = 67;

  fault_debounce_latch_manager i_dut (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_stall         (req_stall),
    .operation         (operation),
    .fault_index       (fault_index),
    .condition_present (condition_present),
    .elapsed_ms        (elapsed_ms),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .active_mask       (active_mask),
    .set_mask          (set_mask),
    .cleared_mask      (cleared_mask),
    .worst_severity    (worst_severity)
  );

  always #10 clk = ~clk;

  initial begin
    for (int i = 0; i < FAULTS; i++) begin
      on_time[i]  = '0;
      off_time[i] = '0;
    end
  end

  function automatic fault_limits_t limits_of(input logic [3:0] id);
    fault_limits_t l;
    case (id)
      4'd0:    l = {fdlm_pkg::SEV_CRITICAL, 16'd0,   16'd0,    1'b0};
      4'd1:    l = {fdlm_pkg::SEV_CRITICAL, 16'd20,  16'd500,  1'b0};
      4'd2:    l = {fdlm_pkg::SEV_LIMP,     16'd0,   16'd0,    1'b0};
      4'd3:    l = {fdlm_pkg::SEV_WARN,     16'd50,  16'd500,  1'b0};
      4'd4:    l = {fdlm_pkg::SEV_CRITICAL, 16'd0,   16'd0,    1'b1};
      4'd5:    l = {fdlm_pkg::SEV_CRITICAL, 16'd0,   16'd0,    1'b1};
      4'd6:    l = {fdlm_pkg::SEV_CRITICAL, 16'd100, 16'd1000, 1'b0};
      4'd7:    l = {fdlm_pkg::SEV_CRITICAL, 16'd50,  16'd1000, 1'b1};
      4'd8:    l = {fdlm_pkg::SEV_CRITICAL, 16'd100, 16'd1000, 1'b0};
      4'd9:    l = {fdlm_pkg::SEV_CRITICAL, 16'd50,  16'd1000, 1'b1};
      4'd10:   l = {fdlm_pkg::SEV_DERATE,   16'd200, 16'd2000, 1'b0};
      4'd11:   l = {fdlm_pkg::SEV_DERATE,   16'd500, 16'd5000, 1'b0};
      4'd12:   l = {fdlm_pkg::SEV_DERATE,   16'd500, 16'd5000, 1'b0};
      4'd13:   l = {fdlm_pkg::SEV_LIMP,     16'd50,  16'd500,  1'b0};
      4'd14:   l = {fdlm_pkg::SEV_CRITICAL, 16'd100, 16'd1000, 1'b0};
      default: l = {fdlm_pkg::SEV_INFO,     16'd0,   16'd0,    1'b0};
    endcase
    return l;
  endfunction

  // Applies one accepted word to the local state and returns the status word it should give.
  function automatic fault_status_t advance_faults(input logic [1:0] op, input logic [3:0] id,
                                                   input logic pres, input logic [15:0] dt);
    fault_limits_t lim;
    fault_status_t s;
    logic [16:0]   sum;
    int            i;
    case (op)
      fdlm_pkg::OP_REPORT: begin
        // index 15 is off the end of the table: nothing moves
        if (id < FAULTS) begin
          lim = limits_of(id);
          if (pres) begin
            off_time[id] = '0;
            sum = {1'b0, on_time[id]} + {1'b0, dt};
            on_time[id] = sum[16] ? 16'hFFFF : sum[15:0];
            if (!active_now[id] && on_time[id] >= lim.set_after) begin
              active_now[id] = 1'b1;
              set_since[id]  = 1'b1;
              sets_seen++;
            end
          end else begin
            on_time[id] = '0;
            sum = {1'b0, off_time[id]} + {1'b0, dt};
            off_time[id] = sum[16] ? 16'hFFFF : sum[15:0];
            if (active_now[id] && !lim.latches && off_time[id] >= lim.heal_after) begin
              active_now[id]    = 1'b0;
              cleared_since[id] = 1'b1;
              clears_seen++;
            end
          end
        end
      end
      fdlm_pkg::OP_ACK: begin
        // only latched faults whose condition has gone away are released
        for (i = 0; i < FAULTS; i++) begin
          lim = limits_of(i[3:0]);
          if (active_now[i] && lim.latches && on_time[i] == 16'd0) begin
            active_now[i]    = 1'b0;
            cleared_since[i] = 1'b1;
            clears_seen++;
          end
        end
      end
      fdlm_pkg::OP_BEGIN: begin
        set_since     = '0;
        cleared_since = '0;
      end
      default: ;
    endcase
    s.active   = active_now;
    s.set_bits = set_since;
    s.cleared  = cleared_since;
    s.worst    = fdlm_pkg::SEV_INFO;
    for (i = 0; i < FAULTS; i++) begin
      lim = limits_of(i[3:0]);
      if (active_now[i] && lim.sev > s.worst) s.worst = lim.sev;
    end
    return s;
  endfunction

  // Directed table.  Columns: operation, fault, present, elapsed ms, then either PREDICT
  // or TYPED followed by active, set, cleared masks and worst severity.
  function automatic stim_word_t directed_row(input int n);
    stim_word_t r;
    case (n)
      // fresh from reset, nothing moves
      0:  r = {fdlm_pkg::OP_BEGIN,  4'd0,  1'b0, 16'h0000,
               TYPED, 15'h0000, 15'h0000, 15'h0000, fdlm_pkg::SEV_INFO};
      1:  r = {fdlm_pkg::OP_ACK,    4'd0,  1'b0, 16'h0000,
               TYPED, 15'h0000, 15'h0000, 15'h0000, fdlm_pkg::SEV_INFO};
      2:  r = {OP_SPARE,            4'd15, 1'b1, 16'hFFFF,
               TYPED, 15'h0000, 15'h0000, 15'h0000, fdlm_pkg::SEV_INFO};
      // index past the table
      3:  r = {fdlm_pkg::OP_REPORT, 4'd15, 1'b1, 16'hFFFF,
               TYPED, 15'h0000, 15'h0000, 15'h0000, fdlm_pkg::SEV_INFO};
      // zero debounce sets on zero elapsed, zero heal clears on zero elapsed
      4:  r = {fdlm_pkg::OP_REPORT, 4'd0,  1'b1, 16'h0000,
               TYPED, 15'h0001, 15'h0001, 15'h0000, fdlm_pkg::SEV_CRITICAL};
      5:  r = {fdlm_pkg::OP_REPORT, 4'd0,  1'b0, 16'h0000,
               TYPED, 15'h0000, 15'h0001, 15'h0001, fdlm_pkg::SEV_INFO};
      6:  r = {fdlm_pkg::OP_REPORT, 4'd4,  1'b1, 16'h0000,
               TYPED, 15'h0010, 15'h0011, 15'h0001, fdlm_pkg::SEV_CRITICAL};
      // latched: a long absence does not heal, the acknowledge does
      7:  r = {fdlm_pkg::OP_REPORT, 4'd4,  1'b0, 16'hFFFF, PREDICT};
      8:  r = {fdlm_pkg::OP_ACK,    4'd0,  1'b0, 16'h0000, PREDICT};
      // timer saturation, then heal exactly at the heal time
      9:  r = {fdlm_pkg::OP_REPORT, 4'd1,  1'b1, 16'hFFFF, PREDICT};
      10: r = {fdlm_pkg::OP_REPORT, 4'd1,  1'b1, 16'hFFFF, PREDICT};
      11: r = {fdlm_pkg::OP_REPORT, 4'd1,  1'b0, 16'd499,  PREDICT};
      12: r = {fdlm_pkg::OP_REPORT, 4'd1,  1'b0, 16'd1,    PREDICT};
      // acknowledge ignored while the condition is still present
      13: r = {fdlm_pkg::OP_REPORT, 4'd9,  1'b1, 16'd50,   PREDICT};
      14: r = {fdlm_pkg::OP_ACK,    4'd3,  1'b1, 16'h5555, PREDICT};
      15: r = {fdlm_pkg::OP_REPORT, 4'd9,  1'b0, 16'd0,    PREDICT};
      16: r = {fdlm_pkg::OP_ACK,    4'd12, 1'b0, 16'hAAAA, PREDICT};
      // mixed severities for the worst-severity output
      17: r = {fdlm_pkg::OP_REPORT, 4'd2,  1'b1, 16'd1,    PREDICT};
      18: r = {fdlm_pkg::OP_REPORT, 4'd11, 1'b1, 16'd500,  PREDICT};
      19: r = {fdlm_pkg::OP_BEGIN,  4'd5,  1'b1, 16'hFFFF, PREDICT};
      20: r = {fdlm_pkg::OP_REPORT, 4'd14, 1'b1, 16'hAAAA, PREDICT};
      21: r = {fdlm_pkg::OP_REPORT, 4'd10, 1'b1, 16'h5555, PREDICT};
      22: r = {OP_SPARE,            4'd6,  1'b0, 16'hAAAA, PREDICT};
      // one short of the debounce time, then across it
      23: r = {fdlm_pkg::OP_REPORT, 4'd7,  1'b1, 16'd49,   PREDICT};
      default: r = {fdlm_pkg::OP_REPORT, 4'd7, 1'b1, 16'd1, PREDICT};
    endcase
    return r;
  endfunction

  // Every mismatch passes through here: one line, one count.
  task automatic flag_error(input string msg);
    $display("mismatch @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      flag_error($sformatf("result %0d %s got 0x%0h want 0x%0h", results_seen, name, got, want));
  endtask

  // Receiver: random stall per the current mix, a fresh draw every cycle.
  always @(posedge clk) rsp_stall <= ($urandom_range(99) < rsp_pct);

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_status.size());
      $display("status: fail");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge, before any register moves.  Request first, so a
  // word accepted at this edge is queued ahead of any result taken at the same edge.
  always @(posedge clk) begin : watch_ports
    fault_status_t predicted;
    fault_status_t got;
    fault_status_t want;
    stim_word_t    row;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        predicted = advance_faults(operation, fault_index, condition_present, elapsed_ms);
        row = stim_words[words_in];
        pending_status.push_back(row.typed ? row.want : predicted);
        words_in++;
      end
      if (rsp_valid && !rsp_stall) begin
        got = {active_mask, set_mask, cleared_mask, worst_severity};
        if (pending_status.size() == 0) begin
          flag_error($sformatf("result word 0x%0h with nothing pending", got));
        end else begin
          want = pending_status.pop_front();
          check_field("active_mask",    int'(got.active),   int'(want.active));
          check_field("set_mask",       int'(got.set_bits), int'(want.set_bits));
          check_field("cleared_mask",   int'(got.cleared),  int'(want.cleared));
          check_field("worst_severity", int'(got.worst),    int'(want.worst));
        end
        results_seen++;
      end
    end
  end

  initial begin : drive_requests
    stim_word_t  w;
    logic [14:0] trend;
    int          n;
    int          effective;
    int          pick;
    int          roll;

    for (n = 0; n < DIRECTED_ROWS; n++) stim_words.push_back(directed_row(n));

    // Random words.  Each fault follows a slowly flipping trend so that presence and absence
    // come in runs long enough to reach debounce and heal times; a tenth of reports go
    // against the trend to break runs.  Spare ops and index 15 are noise and do not count.
    trend = '0;
    effective = 0;
    while (effective < RANDOM_WORDS) begin
      w = '0;
      w.fault_id = 4'($urandom_range(15));
      w.present  = 1'($urandom_range(1));
      w.elapsed  = 16'($urandom_range(65535));
      pick = $urandom_range(99);
      if (pick < 6) begin
        w.op = fdlm_pkg::OP_ACK;
        effective++;
      end else if (pick < 12) begin
        w.op = fdlm_pkg::OP_BEGIN;
        effective++;
      end else if (pick < 14) begin
        w.op = OP_SPARE;
      end else begin
        w.op = fdlm_pkg::OP_REPORT;
        if ($urandom_range(99) < 3) begin
          w.fault_id = 4'd15;
        end else begin
          w.fault_id = 4'($urandom_range(FAULTS - 1));
          if ($urandom_range(7) == 0) trend[w.fault_id] = ~trend[w.fault_id];
          w.present = ($urandom_range(9) == 0) ? ~trend[w.fault_id] : trend[w.fault_id];
          roll = $urandom_range(9);
          if (roll == 0)      w.elapsed = 16'd0;
          else if (roll == 1) w.elapsed = 16'($urandom_range(65535));
          else if (roll < 6)  w.elapsed = 16'($urandom_range(200));
          else                w.elapsed = 16'($urandom_range(2000));
          effective++;
        end
      end
      stim_words.push_back(w);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < stim_words.size(); n++) begin
      if (n == stim_words.size() / 3) begin
        send_pct = 67;
        rsp_pct  = 27;
      end else if (n == 2 * stim_words.size() / 3) begin
        send_pct = 0;
        rsp_pct  = 0;
      end
      // sender gap ahead of the word
      while ($urandom_range(99) < send_pct) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
      w = stim_words[n];
      req_valid         <= 1'b1;
      operation         <= w.op;
      fault_index       <= w.fault_id;
      condition_present <= w.present;
      elapsed_ms        <= w.elapsed;
      @(posedge clk);
      while (req_stall) @(posedge clk);
    end
    req_valid <= 1'b0;

    // one more edge so the last word is surely queued, then drain
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_status.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_status.size()));

    $display("covered %0d request words (%0d directed) and %0d results over three idling mixes",
             words_in, DIRECTED_ROWS, results_seen);
    $display("faults set %0d times, cleared %0d times; %0d mismatches", sets_seen, clears_seen,
             mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
